/* hw/rtl/cau_pkg.sv */
// Complex arithmetic unit: shared types, action codes and saturation helper.
// No dependencies; used by cau_front, cau_step, cau_back and the top level.
package cau_pkg;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_CMP = 3'd4;
  localparam logic [2:0] ACT_MAG = 3'd5;

  // One quotient bit and one root bit per step; 34 quotient bits are enough
  // to tell every saturating quotient from a representable one.
  localparam int STEPS = 34;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] d_re;      // direct result for add, sub, mul, cmp
    logic [31:0] d_im;
    logic        d_ovf;
    logic        d_cmp;
    logic        dz;
    logic        neg_re;
    logic        neg_im;
    logic        big_re;
    logic        big_im;
    logic [63:0] den;
    logic [63:0] rem_re;
    logic [63:0] rem_im;
    logic [33:0] num_re;    // dividend bits still to bring down, MSB first
    logic [33:0] num_im;
    logic [33:0] q_re;
    logic [33:0] q_im;
    logic [67:0] sq_v;      // radicand, two bits consumed per step
    logic [33:0] sq_rem;
    logic [33:0] sq_root;
  } cau_step_t;

  // Sign-magnitude to saturated 32-bit part; returns {overflow, value}.
  function automatic logic [32:0] sat_sm(input logic neg, input logic big,
                                         input logic [63:0] mag);
    logic [63:0] n;
    n = ~mag + 64'd1;
    if (neg) begin
      if (big || (mag > 64'h0000_0000_8000_0000)) return {1'b1, 32'h8000_0000};
      return {1'b0, n[31:0]};
    end
    if (big || (mag > 64'h0000_0000_7FFF_FFFF)) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, mag[31:0]};
  endfunction

endpackage

/* hw/rtl/cau_front.sv */
// Front end of the complex arithmetic unit: products, sums, magnitudes and
// divider set-up over four register stages. Depends on cau_pkg.
module cau_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0]          action,
  input  logic signed [31:0]  a_re,
  input  logic signed [31:0]  a_im,
  input  logic signed [31:0]  b_re,
  input  logic signed [31:0]  b_im,
  output logic                out_valid,
  output cau_pkg::cau_step_t  st
);

  localparam int NW = 64 + FRAC_BITS;
  localparam int HW = NW - cau_pkg::STEPS;

  // stage 1
  logic        v1;
  logic [2:0]  act1;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir, p_aa, p_ai, p_bb, p_bi;
  logic [31:0] as_re1, as_im1;
  logic        as_ovf1;
  // stage 2
  logic        v2;
  logic [2:0]  act2;
  logic [64:0] s_re, s_im;
  logic [63:0] ma2, den2;
  logic [31:0] as_re2, as_im2;
  logic        as_ovf2;
  // stage 3
  logic        v3;
  logic [2:0]  act3;
  logic [63:0] mag_re, mag_im, ma3, den3;
  logic        neg_re3, neg_im3, cmp3;
  logic [31:0] as_re3, as_im3;
  logic        as_ovf3;

  logic [32:0] sum_re, sum_im;
  logic [31:0] sat_re, sat_im;
  logic        ovf_re, ovf_im;
  logic [64:0] m_re, m_im, dv_re, dv_im;
  logic [NW-1:0] n_re, n_im;
  logic [63:0] hi_re, hi_im;
  logic [32:0] mul_re, mul_im;
  cau_pkg::cau_step_t st_next;

  always_comb begin
    if (action == cau_pkg::ACT_SUB) begin
      sum_re = {a_re[31], a_re} - {b_re[31], b_re};
      sum_im = {a_im[31], a_im} - {b_im[31], b_im};
    end else begin
      sum_re = {a_re[31], a_re} + {b_re[31], b_re};
      sum_im = {a_im[31], a_im} + {b_im[31], b_im};
    end
    ovf_re = sum_re[32] ^ sum_re[31];
    ovf_im = sum_im[32] ^ sum_im[31];
    sat_re = ovf_re ? (sum_re[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_re[31:0];
    sat_im = ovf_im ? (sum_im[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_im[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1    <= action;
      p_rr    <= a_re * b_re;
      p_ii    <= a_im * b_im;
      p_ri    <= a_re * b_im;
      p_ir    <= a_im * b_re;
      p_aa    <= a_re * a_re;
      p_ai    <= a_im * a_im;
      p_bb    <= b_re * b_re;
      p_bi    <= b_im * b_im;
      as_re1  <= sat_re;
      as_im1  <= sat_im;
      as_ovf1 <= ovf_re | ovf_im;
    end
  end

  always_comb begin
    m_re  = {p_rr[63], p_rr} - {p_ii[63], p_ii};
    m_im  = {p_ri[63], p_ri} + {p_ir[63], p_ir};
    dv_re = {p_rr[63], p_rr} + {p_ii[63], p_ii};
    dv_im = {p_ir[63], p_ir} - {p_ri[63], p_ri};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act2    <= act1;
      s_re    <= (act1 == cau_pkg::ACT_DIV) ? dv_re : m_re;
      s_im    <= (act1 == cau_pkg::ACT_DIV) ? dv_im : m_im;
      ma2     <= p_aa + p_ai;
      den2    <= p_bb + p_bi;
      as_re2  <= as_re1;
      as_im2  <= as_im1;
      as_ovf2 <= as_ovf1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act3    <= act2;
      neg_re3 <= s_re[64];
      neg_im3 <= s_im[64];
      mag_re  <= s_re[64] ? (~s_re[63:0] + 64'd1) : s_re[63:0];
      mag_im  <= s_im[64] ? (~s_im[63:0] + 64'd1) : s_im[63:0];
      ma3     <= ma2;
      den3    <= den2;
      cmp3    <= ma2 < den2;
      as_re3  <= as_re2;
      as_im3  <= as_im2;
      as_ovf3 <= as_ovf2;
    end
  end

  always_comb begin
    n_re   = {mag_re, {FRAC_BITS{1'b0}}};
    n_im   = {mag_im, {FRAC_BITS{1'b0}}};
    hi_re  = {{(64 - HW){1'b0}}, n_re[NW-1:cau_pkg::STEPS]};
    hi_im  = {{(64 - HW){1'b0}}, n_im[NW-1:cau_pkg::STEPS]};
    mul_re = cau_pkg::sat_sm(neg_re3, 1'b0, mag_re >> FRAC_BITS);
    mul_im = cau_pkg::sat_sm(neg_im3, 1'b0, mag_im >> FRAC_BITS);

    st_next         = '0;
    st_next.action  = act3;
    st_next.dz      = (den3 == 64'd0);
    st_next.neg_re  = neg_re3;
    st_next.neg_im  = neg_im3;
    st_next.big_re  = hi_re >= den3;
    st_next.big_im  = hi_im >= den3;
    st_next.den     = den3;
    st_next.rem_re  = hi_re;
    st_next.rem_im  = hi_im;
    st_next.num_re  = n_re[cau_pkg::STEPS-1:0];
    st_next.num_im  = n_im[cau_pkg::STEPS-1:0];
    st_next.sq_v    = {4'b0, ma3};
    unique case (act3)
      cau_pkg::ACT_ADD, cau_pkg::ACT_SUB: begin
        st_next.d_re  = as_re3;
        st_next.d_im  = as_im3;
        st_next.d_ovf = as_ovf3;
      end
      cau_pkg::ACT_MUL: begin
        st_next.d_re  = mul_re[31:0];
        st_next.d_im  = mul_im[31:0];
        st_next.d_ovf = mul_re[32] | mul_im[32];
      end
      cau_pkg::ACT_CMP: st_next.d_cmp = cmp3;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) st <= st_next;
  end

endmodule

/* hw/rtl/cau_step.sv */
// One stage of the shared step pipeline: a restoring division step for both
// quotient parts and a two-bit root step. Depends on cau_pkg.
module cau_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  cau_pkg::cau_step_t in_st,
  output logic               out_valid,
  output cau_pkg::cau_step_t st
);

  cau_pkg::cau_step_t st_next;
  logic [64:0] r2_re, r2_im, d65;
  logic        ge_re, ge_im;
  logic [35:0] sr2, trial;
  logic        ge_sq;

  always_comb begin
    d65   = {1'b0, in_st.den};
    r2_re = {in_st.rem_re, in_st.num_re[33]};
    r2_im = {in_st.rem_im, in_st.num_im[33]};
    ge_re = r2_re >= d65;
    ge_im = r2_im >= d65;
    sr2   = {in_st.sq_rem, in_st.sq_v[67:66]};
    trial = {in_st.sq_root, 2'b01};
    ge_sq = sr2 >= trial;

    st_next        = in_st;
    st_next.rem_re = ge_re ? 64'(r2_re - d65) : r2_re[63:0];
    st_next.rem_im = ge_im ? 64'(r2_im - d65) : r2_im[63:0];
    st_next.num_re = {in_st.num_re[32:0], 1'b0};
    st_next.num_im = {in_st.num_im[32:0], 1'b0};
    st_next.q_re   = {in_st.q_re[32:0], ge_re};
    st_next.q_im   = {in_st.q_im[32:0], ge_im};
    // remainder stays below 2*root+1, so 34 bits hold it
    st_next.sq_rem  = ge_sq ? 34'(sr2 - trial) : sr2[33:0];
    st_next.sq_root = {in_st.sq_root[32:0], ge_sq};
    st_next.sq_v    = {in_st.sq_v[65:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st <= st_next;
  end

endmodule

/* hw/rtl/cau_back.sv */
// Output stage: saturates quotient and root, selects the result and holds
// it in the output register. Depends on cau_pkg.
module cau_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  cau_pkg::cau_step_t in_st,
  output logic               out_valid,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic               compare_flag,
  output logic               overflow,
  output logic               divide_by_zero
);

  logic [32:0] q_re, q_im, rt;
  logic [31:0] re_next, im_next;
  logic        cmp_next, ovf_next, dz_next;

  always_comb begin
    q_re = cau_pkg::sat_sm(in_st.neg_re, in_st.big_re, {30'b0, in_st.q_re});
    q_im = cau_pkg::sat_sm(in_st.neg_im, in_st.big_im, {30'b0, in_st.q_im});
    rt   = cau_pkg::sat_sm(1'b0, 1'b0, {30'b0, in_st.sq_root});
    re_next  = in_st.d_re;
    im_next  = in_st.d_im;
    cmp_next = in_st.d_cmp;
    ovf_next = in_st.d_ovf;
    dz_next  = 1'b0;
    unique case (in_st.action)
      cau_pkg::ACT_DIV: begin
        if (in_st.dz) begin
          re_next  = '0;
          im_next  = '0;
          ovf_next = 1'b0;
          dz_next  = 1'b1;
        end else begin
          re_next  = q_re[31:0];
          im_next  = q_im[31:0];
          ovf_next = q_re[32] | q_im[32];
        end
      end
      cau_pkg::ACT_MAG: begin
        re_next  = rt[31:0];
        im_next  = '0;
        ovf_next = rt[32];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re         <= re_next;
      res_im         <= im_next;
      compare_flag   <= cmp_next;
      overflow       <= ovf_next;
      divide_by_zero <= dz_next;
    end
  end

endmodule

/* hw/rtl/complex_arithmetic_unit_core.sv */
// Complex arithmetic unit, top level: front end, step pipeline, output stage.
// Depends on cau_pkg, cau_front, cau_step and cau_back.
//
// Input channel: in_valid/in_stall with action and operands a, b in signed
// fixed point (FRAC_BITS fraction bits). Output channel: out_valid/out_stall
// with res_re, res_im and the compare, overflow and divide-by-zero flags.
// A beat is taken on each edge with valid high and stall low.
// The pipeline has four front stages (products, sums, magnitudes,
// divider set-up), 34 step stages, each one quotient bit per part and one
// root bit, and the output register. One beat enters every cycle while in_stall is low.
// The whole pipeline advances as one; while the output beat is stalled
// every stage holds and in_stall is high, so nothing is lost or repeated.
// Reset clears all valid bits; the pipeline comes up empty and ready.
module complex_arithmetic_unit_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         action,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic               compare_flag,
  output logic               overflow,
  output logic               divide_by_zero
);

  logic en;
  logic               vc [0:cau_pkg::STEPS];
  cau_pkg::cau_step_t sc [0:cau_pkg::STEPS];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .en, .in_valid, .action, .a_re, .a_im, .b_re, .b_im,
    .out_valid(vc[0]), .st(sc[0])
  );

  for (genvar k = 0; k < cau_pkg::STEPS; k++) begin : g_step
    cau_step u_step (
      .clk, .rst, .en,
      .in_valid(vc[k]), .in_st(sc[k]),
      .out_valid(vc[k+1]), .st(sc[k+1])
    );
  end

  cau_back u_back (
    .clk, .rst, .en,
    .in_valid(vc[cau_pkg::STEPS]), .in_st(sc[cau_pkg::STEPS]),
    .out_valid, .res_re, .res_im, .compare_flag, .overflow, .divide_by_zero
  );

endmodule

/* hw/rtl/cau_checker.sv */
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends only on the top level's ports.
module cau_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] res_re,
  input logic signed [31:0] res_im,
  input logic               compare_flag,
  input logic               overflow,
  input logic               divide_by_zero
);

  // stalled output beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_re) && $stable(res_im))
    else $error("stalled output beat changed");

  // input side stalls only when the output beat is held
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output stall");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> res_re == 0 && res_im == 0 && !overflow)
    else $error("divide by zero beat carries data");

  a_cmp_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_flag |-> !overflow && !divide_by_zero && res_re == 0)
    else $error("compare beat carries other results");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (.*);

/* dv/complex_arithmetic_unit_core_tb.sv */
// Testbench for complex_arithmetic_unit_core: random and corner-case beats, each result
// predicted in 128-bit integer arithmetic and checked in order by a small scoreboard.
// Depends on cau_pkg and the RTL of the unit.
module complex_arithmetic_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int LATENCY = 39;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        cmp;
    logic        ovf;
    logic        dz;
  } cau_result_t;

  int errors = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  // Saturate a signed wide value to a 32-bit part.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, ref logic ovf);
    if (v > 128'sd2147483647) begin ovf = 1; return 32'h7FFF_FFFF; end
    if (v < -128'sd2147483648) begin ovf = 1; return 32'h8000_0000; end
    return v[31:0];
  endfunction

  // Truncate toward zero after scaling.
  function automatic logic signed [127:0] div_trunc(input logic signed [127:0] n,
                                                    input logic signed [127:0] d);
    logic signed [127:0] an;
    an = (n < 0) ? -n : n;
    an = an / d;
    return (n < 0) ? -an : an;
  endfunction

  function automatic logic [63:0] floor_root(input logic [127:0] v);
    logic [127:0] r, b;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      b = r | (128'd1 << i);
      if (b * b <= v) r = b;
    end
    return r[63:0];
  endfunction

  function automatic cau_result_t compute_result(input logic [2:0] act,
      input logic signed [31:0] ar, ai, br, bi);
    cau_result_t r;
    logic ovf;
    logic signed [127:0] xr, xi, yr, yi, den, ma;
    r = '0;
    ovf = 0;
    xr = ar; xi = ai; yr = br; yi = bi;
    case (act)
      cau_pkg::ACT_ADD: begin
        r.re = clamp32(xr + yr, ovf); r.im = clamp32(xi + yi, ovf);
      end
      cau_pkg::ACT_SUB: begin
        r.re = clamp32(xr - yr, ovf); r.im = clamp32(xi - yi, ovf);
      end
      cau_pkg::ACT_MUL: begin
        r.re = clamp32(div_trunc(xr * yr - xi * yi, 128'sd1 << FRAC), ovf);
        r.im = clamp32(div_trunc(xr * yi + xi * yr, 128'sd1 << FRAC), ovf);
      end
      cau_pkg::ACT_DIV: begin
        den = yr * yr + yi * yi;
        if (den == 0) r.dz = 1;
        else begin
          r.re = clamp32(div_trunc((xr * yr + xi * yi) <<< FRAC, den), ovf);
          r.im = clamp32(div_trunc((xi * yr - xr * yi) <<< FRAC, den), ovf);
        end
      end
      cau_pkg::ACT_CMP: r.cmp = (xr * xr + xi * xi) < (yr * yr + yi * yi);
      cau_pkg::ACT_MAG: begin
        ma = floor_root(xr * xr + xi * xi);
        r.re = clamp32(ma, ovf);
      end
      default: ;
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  class result_board;
    cau_result_t pending[$];
    int n_in = 0, n_out = 0;

    function void note_beat(input logic [2:0] act, input logic [31:0] ar, ai, br, bi);
      pending.push_back(compute_result(act, ar, ai, br, bi));
      n_in++;
    endfunction

    task check_beat(input cau_result_t got);
      cau_result_t want;
      n_out++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", got.re, 32'd0);
        return;
      end
      want = pending.pop_front();
      if (got.re !== want.re) report_mismatch("res_re", got.re, want.re);
      if (got.im !== want.im) report_mismatch("res_im", got.im, want.im);
      if (got.cmp !== want.cmp)
        report_mismatch("compare_flag", 32'(got.cmp), 32'(want.cmp));
      if (got.ovf !== want.ovf)
        report_mismatch("overflow", 32'(got.ovf), 32'(want.ovf));
      if (got.dz !== want.dz)
        report_mismatch("divide_by_zero", 32'(got.dz), 32'(want.dz));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [2:0] action = '0;
  logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic signed [31:0] res_re, res_im;
  logic compare_flag, overflow, divide_by_zero;
  int send_idle = 0, recv_stall = 0;   // percent
  result_board board;

  complex_arithmetic_unit_core #(.FRAC_BITS(FRAC)) uut (.*);

  initial forever #4 clk = ~clk;

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        board.check_beat('{res_re, res_im, compare_flag, overflow, divide_by_zero});
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // Drive one beat and hold it until taken; valid drops only while idling.
  task automatic send_beat(input logic [2:0] act, input logic [31:0] ar, ai, br, bi);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1;
    action <= act; a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
    do @(posedge clk); while (in_stall);
    board.note_beat(act, ar, ai, br, bi);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return $urandom_range(8) - 4;
      3: return $urandom_range(32'h3_0000) - 32'h1_8000;   // within +/-1.5 at FRAC fraction bits
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] ext[4];
    logic [31:0] op_b_re, op_b_im;
    board = new();
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes for every action, divide by zero, unused codes.
    for (int act = 0; act < 6; act++)
      for (int k = 0; k < 4; k++)
        send_beat(3'(act), ext[k], ext[3 - k], ext[(k + 1) % 4], ext[k]);
    send_beat(cau_pkg::ACT_DIV, 32'h1_0000, 32'h2_0000, 0, 0);
    send_beat(cau_pkg::ACT_DIV, 32'h8000_0000, 32'h8000_0000, 1, 0);
    send_beat(cau_pkg::ACT_MAG, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_beat(3'd6, $urandom, $urandom, $urandom, $urandom);
    send_beat(3'd7, $urandom, $urandom, $urandom, $urandom);
    drain();   // sender holds off until the pipe is empty

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 79; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 79; end
        3: begin send_idle = 37; recv_stall = 37; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      for (int i = 0; i < 380; i++) begin
        op_b_re = pick_operand();
        op_b_im = pick_operand();
        if ($urandom_range(30) == 0) begin op_b_re = 0; op_b_im = 0; end
        send_beat(3'($urandom_range(15) == 0 ? $urandom_range(7, 6) : $urandom_range(5)),
                  pick_operand(), pick_operand(), op_b_re, op_b_im);
      end
    end

    drain();
    repeat (LATENCY + 5) @(posedge clk);
    $display("covered %0d beats in, %0d results out, all actions, extreme operands,",
             board.n_in, board.n_out);
    $display("zero divisors and idle/stall mixes on both channels; %0d mismatches", errors);
    if (errors == 0 && board.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/cau_pkg.sv
hw/rtl/cau_front.sv
hw/rtl/cau_step.sv
hw/rtl/cau_back.sv
hw/rtl/complex_arithmetic_unit_core.sv
hw/rtl/cau_checker.sv
dv/complex_arithmetic_unit_core_tb.sv
